/* rtl/kvrsp_pkg.sv */
// shared types, codes and character constants of the key/value record stream parser
package kvrsp_pkg;

  localparam int unsigned KEY_MAX_DEF = 32;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_Z     = 8'h7A;

  // token kinds
  localparam logic [2:0] TOK_KEY     = 3'd0;
  localparam logic [2:0] TOK_COLON   = 3'd1;
  localparam logic [2:0] TOK_SPACE   = 3'd2;
  localparam logic [2:0] TOK_VALUE   = 3'd3;
  localparam logic [2:0] TOK_FIELD   = 3'd4;
  localparam logic [2:0] TOK_IGNORED = 3'd5;

  // fault codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_KEY    = 3'd1;
  localparam logic [2:0] ERR_KEY_LEN    = 3'd2;
  localparam logic [2:0] ERR_NO_SPACE   = 3'd3;
  localparam logic [2:0] ERR_EMPTY_VAL  = 3'd4;
  localparam logic [2:0] ERR_UNTERM     = 3'd5;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_KEY    = 5'b00010,
    PH_SPACE  = 5'b00100,
    PH_VFIRST = 5'b01000,
    PH_VALUE  = 5'b10000
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic       record_open;
    logic [2:0] failed_code;
  } parse_state_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic       record_done;
    logic       body_done;
    logic       body_ok;
    logic [2:0] error_code;
  } result_t;

endpackage

/* rtl/kvrsp_parser.sv */
// per-byte parse step: next line state and the result word for one input byte
module kvrsp_parser
  import kvrsp_pkg::*;
#(
  parameter int unsigned KEY_MAX = KEY_MAX_DEF,
  parameter int unsigned CW      = $clog2(KEY_MAX + 1)
) (
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  input  parse_state_t  state_i,
  input  logic [CW-1:0] key_count_i,
  output parse_state_t  state_o,
  output logic [CW-1:0] key_count_o,
  output result_t       result_o
);

  localparam logic [CW-1:0] KEY_LIMIT = CW'(KEY_MAX);

  logic          is_lower;
  logic [CW-1:0] count_inc;
  logic [2:0]    fault;
  logic [2:0]    tok;
  logic          rdone;
  logic          ok;
  parse_state_t  nxt;
  logic [CW-1:0] cnt_nxt;

  assign is_lower  = (data_byte_i >= CHAR_A) && (data_byte_i <= CHAR_Z);
  assign count_inc = key_count_i + CW'(1);

  always_comb begin
    nxt     = state_i;
    cnt_nxt = key_count_i;
    tok     = TOK_IGNORED;
    rdone   = 1'b0;
    ok      = 1'b0;
    fault   = ERR_NONE;

    if (state_i.failed_code == ERR_NONE) begin
      case (state_i.phase)
        PH_START: begin
          if (data_byte_i == CHAR_LF) begin
            // blank line closes an open record
            if (state_i.record_open) begin
              rdone           = 1'b1;
              nxt.record_open = 1'b0;
            end
          end else if (data_byte_i == CHAR_COLON) begin
            fault = ERR_KEY_LEN;
          end else if (is_lower) begin
            tok       = TOK_KEY;
            cnt_nxt   = CW'(1);
            nxt.phase = PH_KEY;
            if (CW'(1) >= KEY_LIMIT) fault = ERR_KEY_LEN;
          end else begin
            fault = ERR_BAD_KEY;
          end
        end
        PH_KEY: begin
          if (data_byte_i == CHAR_COLON) begin
            tok       = TOK_COLON;
            nxt.phase = PH_SPACE;
          end else if (is_lower) begin
            tok     = TOK_KEY;
            cnt_nxt = count_inc;
            if (count_inc >= KEY_LIMIT) fault = ERR_KEY_LEN;
          end else begin
            fault = ERR_BAD_KEY;
          end
        end
        PH_SPACE: begin
          if (data_byte_i == CHAR_SPACE) begin
            tok       = TOK_SPACE;
            nxt.phase = PH_VFIRST;
          end else begin
            fault = ERR_NO_SPACE;
          end
        end
        PH_VFIRST: begin
          if (data_byte_i == CHAR_LF) begin
            fault = ERR_EMPTY_VAL;
          end else begin
            tok       = TOK_VALUE;
            nxt.phase = PH_VALUE;
          end
        end
        default: begin
          if (data_byte_i == CHAR_LF) begin
            tok             = TOK_FIELD;
            nxt.record_open = 1'b1;
            nxt.phase       = PH_START;
            cnt_nxt         = '0;
          end else begin
            tok = TOK_VALUE;
          end
        end
      endcase

      // body ends in the middle of a line
      if (fault == ERR_NONE && last_byte_i && nxt.phase != PH_START) fault = ERR_UNTERM;

      if (fault != ERR_NONE) begin
        nxt.failed_code = fault;
        tok             = TOK_IGNORED;
        rdone           = 1'b0;
      end else if (last_byte_i) begin
        if (nxt.record_open) begin
          rdone           = 1'b1;
          nxt.record_open = 1'b0;
        end
        ok = 1'b1;
      end
    end

    result_o.token_kind  = tok;
    result_o.record_done = rdone;
    result_o.body_done   = last_byte_i;
    result_o.body_ok     = ok;
    result_o.error_code  = nxt.failed_code;

    // everything returns to reset after the last byte
    if (last_byte_i) begin
      nxt.phase       = PH_START;
      nxt.record_open = 1'b0;
      nxt.failed_code = ERR_NONE;
      cnt_nxt         = '0;
    end

    state_o     = nxt;
    key_count_o = cnt_nxt;
  end

endmodule

/* rtl/key_value_record_stream_parser.sv */
// top level of the key/value record stream parser with its output register and skid stage
//
// usage:
//   s_axis carries the record body, one byte per word in s_axis_tdata, with
//   s_axis_tlast high on the final byte of the body. every accepted word yields
//   exactly one result word on m_axis: the token kind in m_axis_tuser, record
//   done, body ok and the latched fault code in m_axis_tdata, and m_axis_tlast
//   on the result of the body's final byte.
//   each result is registered into the output register, or the skid register while m_axis stalls.
//   throughput: one byte per cycle while s_axis_tready is high; the line state
//   update is a single shallow step between the accepted byte and the result register.
//   stalls: while m_axis_tready is low one more byte is taken into a skid
//   register, then s_axis_tready drops until the receiver takes a word.
//   a fault is latched and shown on every later word of the body; the line
//   state clears itself after each final byte.
//   reset: rst_ni clears the line state and empties both output registers.
module key_value_record_stream_parser
  import kvrsp_pkg::*;
#(
  parameter int unsigned KEY_MAX = KEY_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // record_done[0], body_ok[1], error_code[4:2], zero[7:5]
  output logic [2:0] m_axis_tuser,   // token_kind[2:0]
  output logic       m_axis_tlast    // body_done
);

  // key counter holds up to KEY_MAX itself
  localparam int unsigned CW = $clog2(KEY_MAX + 1);

  parse_state_t  state_q, state_d;
  logic [CW-1:0] key_count_q, key_count_d;
  result_t       result;

  // output register and skid register
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  logic push, pop;

  kvrsp_parser #(
    .KEY_MAX (KEY_MAX),
    .CW      (CW)
  ) u_parser (
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .state_i     (state_q),
    .key_count_i (key_count_q),
    .state_o     (state_d),
    .key_count_o (key_count_d),
    .result_o    (result)
  );

  // ready only depends on the skid register being free
  assign s_axis_tready = !skid_valid_q;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  // line state advances once per accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PH_START;
      state_q.record_open <= 1'b0;
      state_q.failed_code <= ERR_NONE;
      key_count_q         <= '0;
    end else if (push) begin
      state_q     <= state_d;
      key_count_q <= key_count_d;
    end
  end

  // valid flags of the two output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload of the two output stages
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !pop) skid_q <= result;
      else out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.token_kind;
  assign m_axis_tlast  = out_q.body_done;
  assign m_axis_tdata  = {3'b000, out_q.error_code, out_q.body_ok, out_q.record_done};

endmodule
